// ===== rtl/piecewise_linear_shade_lookup_top_assert.svh =====
// assertion macros for the shade lookup top level
// depends on nothing; included by piecewise_linear_shade_lookup_top.sv
`ifndef PIECEWISE_LINEAR_SHADE_LOOKUP_TOP_ASSERT_SVH
`define PIECEWISE_LINEAR_SHADE_LOOKUP_TOP_ASSERT_SVH

// same-cycle implication
`define PLSL_ASSERT_NOW(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PLSL_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/plsl_pkg.sv =====
// shared types and constants for the shade lookup block
// depends on nothing
package plsl_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam int DIST_W   = 24;
  localparam int STEP_W   = 24;
  localparam int RECIP_W  = 24;
  localparam int SHADE_W  = 16;
  localparam int SEG_W    = 5;
  localparam int REGION_W = 2;
  localparam int COUNT_W  = 5;
  localparam int HALF_W   = RECIP_W / 2;
  localparam int FRAC_W   = 17;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  localparam logic [REGION_W-1:0] REGION_INTERP = 2'd0;
  localparam logic [REGION_W-1:0] REGION_BELOW  = 2'd1;
  localparam logic [REGION_W-1:0] REGION_BEYOND = 2'd2;

  typedef struct packed {
    logic [STEP_W-1:0]         step;
    logic [RECIP_W-1:0]        recip;
    logic signed [SHADE_W-1:0] shade;
  } plsl_entry_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FETCH,
    ST_WALK,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_FRAC,
    ST_MUL2,
    ST_ROUND,
    ST_FINISH
  } plsl_state_t;

  typedef struct packed {
    logic write;
    logic start;
    logic rd_en;
    logic rd_next;
    logic walk;
    logic set_below;
    logic set_beyond;
    logic mul_lo;
    logic mul_hi;
    logic frac;
    logic mul2;
    logic round;
    logic out_load;
  } plsl_cmd_t;

  typedef struct packed {
    logic le_first;
    logic ge_step;
    logic last;
  } plsl_sts_t;

endpackage

// ===== rtl/plsl_item_if.sv =====
// input channel: load or query beats
// depends on plsl_pkg
interface plsl_item_if;
  import plsl_pkg::*;

  logic                      valid;
  logic                      ready;
  logic                      mode;
  logic [IDX_W-1:0]          entry_index;
  logic [STEP_W-1:0]         entry_step;
  logic [RECIP_W-1:0]        entry_reciprocal;
  logic signed [SHADE_W-1:0] entry_shade;
  logic [DIST_W-1:0]         query_distance;

  modport source (
    output valid, mode, entry_index, entry_step, entry_reciprocal, entry_shade,
           query_distance,
    input  ready
  );

  modport sink (
    input  valid, mode, entry_index, entry_step, entry_reciprocal, entry_shade,
           query_distance,
    output ready
  );
endinterface

// ===== rtl/plsl_result_if.sv =====
// output channel: one beat per query
// depends on plsl_pkg
interface plsl_result_if;
  import plsl_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [SHADE_W-1:0] shade_value;
  logic [SEG_W-1:0]          segment_number;
  logic [REGION_W-1:0]       region_code;

  modport source (
    output valid, shade_value, segment_number, region_code,
    input  ready
  );

  modport sink (
    input  valid, shade_value, segment_number, region_code,
    output ready
  );
endinterface

// ===== rtl/plsl_ctrl.sv =====
// sequencer for table walk and interpolation
// depends on plsl_pkg
module plsl_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  input  logic                item_mode,
  output logic                item_ready,
  input  logic                out_ready,
  output logic                out_valid,
  input  plsl_pkg::plsl_sts_t sts,
  output plsl_pkg::plsl_cmd_t cmd
);
  import plsl_pkg::*;

  plsl_state_t state, state_next;
  logic        out_free;

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (item_valid && item_mode == MODE_QUERY) state_next = ST_FETCH;
      end
      ST_FETCH:  state_next = ST_WALK;
      ST_WALK: begin
        if (sts.le_first) begin
          state_next = ST_FINISH;
        end else if (sts.ge_step) begin
          state_next = sts.last ? ST_FINISH : ST_WALK;
        end else begin
          state_next = ST_MUL_LO;
        end
      end
      ST_MUL_LO: state_next = ST_MUL_HI;
      ST_MUL_HI: state_next = ST_FRAC;
      ST_FRAC:   state_next = ST_MUL2;
      ST_MUL2:   state_next = ST_ROUND;
      ST_ROUND:  state_next = ST_FINISH;
      ST_FINISH: begin
        if (out_free) state_next = ST_IDLE;
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    item_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          cmd.write = (item_mode == MODE_LOAD);
          cmd.start = (item_mode == MODE_QUERY);
        end
      end
      ST_FETCH: cmd.rd_en = 1'b1;
      ST_WALK: begin
        if (sts.le_first) begin
          cmd.set_below = 1'b1;
        end else if (sts.ge_step) begin
          cmd.walk = 1'b1;
          if (sts.last) begin
            cmd.set_beyond = 1'b1;
          end else begin
            cmd.rd_en   = 1'b1;
            cmd.rd_next = 1'b1;
          end
        end else begin
          cmd.mul_lo = 1'b1;
        end
      end
      ST_MUL_LO: cmd.mul_hi = 1'b1;
      ST_MUL_HI: cmd.frac   = 1'b1;
      ST_FRAC:   cmd.mul2   = 1'b1;
      ST_MUL2:   cmd.round  = 1'b1;
      ST_ROUND:  cmd        = '0;
      ST_FINISH: cmd.out_load = out_free;
      default:   cmd        = '0;
    endcase
  end
endmodule

// ===== rtl/plsl_datapath.sv =====
// breakpoint memory, residual walk and interpolation arithmetic
// depends on plsl_pkg
module plsl_datapath (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [plsl_pkg::COUNT_W-1:0]         cfg_data,
  input  logic [plsl_pkg::IDX_W-1:0]           entry_index,
  input  logic [plsl_pkg::STEP_W-1:0]          entry_step,
  input  logic [plsl_pkg::RECIP_W-1:0]         entry_reciprocal,
  input  logic signed [plsl_pkg::SHADE_W-1:0]  entry_shade,
  input  logic [plsl_pkg::DIST_W-1:0]          query_distance,
  input  plsl_pkg::plsl_cmd_t                  cmd,
  output plsl_pkg::plsl_sts_t                  sts,
  output logic signed [plsl_pkg::SHADE_W-1:0]  shade_value,
  output logic [plsl_pkg::SEG_W-1:0]           segment_number,
  output logic [plsl_pkg::REGION_W-1:0]        region_code
);
  import plsl_pkg::*;

  localparam int PLO_W  = DIST_W + HALF_W;
  localparam int PSUM_W = DIST_W + RECIP_W;
  localparam int P2_W   = FRAC_W + 1 + SHADE_W + 1;
  localparam int RND_W  = P2_W - 16;
  localparam int SUM_W  = RND_W + 1;

  plsl_entry_t mem [TABLE_DEPTH];
  plsl_entry_t rdata;

  logic [COUNT_W-1:0]        count;
  logic [CNT_W-1:0]          active;
  logic [IDX_W-1:0]          idx;
  logic [IDX_W-1:0]          rd_addr;
  logic [DIST_W-1:0]         resid;
  logic [RECIP_W-1:0]        prev_recip;
  logic signed [SHADE_W-1:0] prev_shade;
  logic signed [SHADE_W:0]   diff;
  logic [PLO_W-1:0]          plo;
  logic [PLO_W-1:0]          phi;
  logic [FRAC_W-1:0]         frac;
  logic signed [P2_W-1:0]    prod;
  logic signed [SHADE_W-1:0] res_shade;
  logic [SEG_W-1:0]          res_seg;
  logic [REGION_W-1:0]       res_region;

  logic [PSUM_W-1:0]         psum;
  logic [PSUM_W-9:0]         frac_wide;
  logic signed [P2_W-1:0]    prod_rnd;
  logic signed [RND_W-1:0]   rnd;
  logic signed [SUM_W-1:0]   sum;

  // table slots in use, clamped to one through depth
  always_comb begin
    if (count == '0) begin
      active = CNT_W'(1);
    end else if (CNT_W'(count) > CNT_W'(TABLE_DEPTH)) begin
      active = CNT_W'(TABLE_DEPTH);
    end else begin
      active = CNT_W'(count);
    end
  end

  assign rd_addr = cmd.rd_next ? idx + IDX_W'(1) : idx;

  always_ff @(posedge clk) begin
    if (cmd.write && (CNT_W'(entry_index) < CNT_W'(TABLE_DEPTH))) begin
      mem[entry_index] <= '{step: entry_step, recip: entry_reciprocal,
                            shade: entry_shade};
    end
    if (cmd.rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  assign sts.le_first = (idx == '0) && (resid <= rdata.step);
  assign sts.ge_step  = (resid >= rdata.step);
  assign sts.last     = (CNT_W'(idx) == active - CNT_W'(1));

  assign psum      = {phi, {HALF_W{1'b0}}} + PSUM_W'(plo);
  assign frac_wide = psum[PSUM_W-1:8];
  assign prod_rnd  = prod + P2_W'(32768);
  assign rnd       = prod_rnd[P2_W-1:16];
  assign sum       = SUM_W'(prev_shade) + SUM_W'(rnd);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= COUNT_W'(1);
    end else if (cfg_write) begin
      count <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      resid <= query_distance;
      idx   <= '0;
    end
    if (cmd.walk) begin
      resid      <= resid - rdata.step;
      prev_recip <= rdata.recip;
      prev_shade <= rdata.shade;
      idx        <= idx + IDX_W'(1);
    end
    if (cmd.set_below) begin
      res_shade  <= rdata.shade;
      res_seg    <= '0;
      res_region <= REGION_BELOW;
    end
    if (cmd.set_beyond) begin
      res_shade  <= rdata.shade;
      res_seg    <= SEG_W'(idx) + SEG_W'(1);
      res_region <= REGION_BEYOND;
    end
    if (cmd.mul_lo) begin
      plo        <= resid * prev_recip[HALF_W-1:0];
      diff       <= (SHADE_W+1)'(rdata.shade) - (SHADE_W+1)'(prev_shade);
      res_seg    <= SEG_W'(idx);
      res_region <= REGION_INTERP;
    end
    if (cmd.mul_hi) begin
      phi <= resid * prev_recip[RECIP_W-1:HALF_W];
    end
    if (cmd.frac) begin
      // fraction saturates at one
      if (frac_wide > (PSUM_W-8)'(65536)) begin
        frac <= FRAC_W'(65536);
      end else begin
        frac <= frac_wide[FRAC_W-1:0];
      end
    end
    if (cmd.mul2) begin
      prod <= P2_W'($signed({1'b0, frac}) * diff);
    end
    if (cmd.round) begin
      if (sum > SUM_W'(32767)) begin
        res_shade <= 16'sh7fff;
      end else if (sum < -SUM_W'(32768)) begin
        res_shade <= 16'sh8000;
      end else begin
        res_shade <= sum[SHADE_W-1:0];
      end
    end
    // output register, held while the result beat waits
    if (cmd.out_load) begin
      shade_value    <= res_shade;
      segment_number <= res_seg;
      region_code    <= res_region;
    end
  end
endmodule

// ===== rtl/piecewise_linear_shade_lookup_top.sv =====
// top level of the piecewise-linear shade lookup
// depends on plsl_pkg, plsl_item_if, plsl_result_if, plsl_ctrl, plsl_datapath and the assertion macro header
//
//   channel   kind        payload
//   item      sink        mode, entry_index, entry_step, entry_reciprocal,
//                         entry_shade, query_distance
//   result    source      shade_value, segment_number, region_code
//   cfg       write only  entry_count (cfg_write, cfg_data)
//
// load beat: written in the idle state, no result
// query: one memory read per entry walked; at either end of the table the result
//   is set directly; interpolation adds a split multiply, fraction, multiply, rounding
// reset: entry_count back to 1, table memory not cleared
// a finished result sits in the output register; the next beat is taken meanwhile,
//   and a query that finishes while that result is still held waits in its last cycle
module piecewise_linear_shade_lookup_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [plsl_pkg::COUNT_W-1:0]  cfg_data,
  plsl_item_if.sink                     item,
  plsl_result_if.source                 result
);
  import plsl_pkg::*;
  `include "piecewise_linear_shade_lookup_top_assert.svh"

  plsl_cmd_t cmd;
  plsl_sts_t sts;

  plsl_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item.valid),
    .item_mode  (item.mode),
    .item_ready (item.ready),
    .out_ready  (result.ready),
    .out_valid  (result.valid),
    .sts        (sts),
    .cmd        (cmd)
  );

  plsl_datapath u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cfg_write        (cfg_write),
    .cfg_data         (cfg_data),
    .entry_index      (item.entry_index),
    .entry_step       (item.entry_step),
    .entry_reciprocal (item.entry_reciprocal),
    .entry_shade      (item.entry_shade),
    .query_distance   (item.query_distance),
    .cmd              (cmd),
    .sts              (sts),
    .shade_value      (result.shade_value),
    .segment_number   (result.segment_number),
    .region_code      (result.region_code)
  );

  `PLSL_ASSERT_NEXT(a_load_stays_ready, clk, rst,
    item.valid && item.ready && item.mode == MODE_LOAD, item.ready,
    "load beat left the block busy")
  `PLSL_ASSERT_NEXT(a_query_goes_busy, clk, rst,
    item.valid && item.ready && item.mode == MODE_QUERY, !item.ready,
    "query beat did not start a walk")
  `PLSL_ASSERT_NOW(a_below_seg_zero, clk, rst,
    result.valid && result.region_code == REGION_BELOW, result.segment_number == '0,
    "below-first result with nonzero segment")
  `PLSL_ASSERT_NOW(a_beyond_seg_nonzero, clk, rst,
    result.valid && result.region_code == REGION_BEYOND, result.segment_number != '0,
    "beyond-last result with zero segment")
endmodule
